/* sv/lav_pkg.sv */
package lav_pkg;

    // Width of a vector component entering a normalizer (holds a Q3.60 cross product).
    localparam int unsigned VEC_W = 63;

    // Pipeline depth of one normalizer, from its input register to its output register.
    localparam int unsigned NORM_LAT = 70;

    // Row codes.
    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_BACK = 2'd2;

    typedef logic signed [VEC_W-1:0] t_wide;
    typedef logic signed [31:0]      t_q230;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [39:0] shift_term;
        logic               degenerate;
        logic               last_row;
    } t_out_beat;

endpackage

/* sv/lav_norm.sv */
module lav_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  lav_pkg::t_wide i_vec [0:2],
    output lav_pkg::t_q230 o_unit [0:2],
    output logic           o_zero
);
    import lav_pkg::*;

    localparam int unsigned MAG_W    = VEC_W - 1;
    localparam int unsigned FRAC_W   = 30;
    localparam int unsigned POS_W    = $clog2(MAG_W);
    localparam int unsigned SQ_W     = 2 * FRAC_W;
    localparam int unsigned S_W      = 2 * FRAC_W + 2;
    localparam int unsigned LEN_W    = FRAC_W + 1;
    localparam int unsigned NUM_W    = 2 * FRAC_W;
    localparam int unsigned SQ_STEPS = LEN_W;
    localparam int unsigned DV_STEPS = LEN_W;

    // Stage A: magnitudes and signs.
    logic [MAG_W-1:0] r_a_mag [0:2];
    logic [2:0]       r_a_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a_neg[j] <= i_vec[j][VEC_W-1];
                r_a_mag[j] <= MAG_W'(i_vec[j][VEC_W-1] ? -i_vec[j] : i_vec[j]);
            end
        end
    end

    // Stage B: largest magnitude.
    logic [MAG_W-1:0] n_b_max;
    logic [MAG_W-1:0] r_b_max;
    logic [MAG_W-1:0] r_b_mag [0:2];
    logic [2:0]       r_b_neg;

    always_comb begin
        n_b_max = r_a_mag[0];
        if (r_a_mag[1] > n_b_max) begin
            n_b_max = r_a_mag[1];
        end
        if (r_a_mag[2] > n_b_max) begin
            n_b_max = r_a_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_max <= n_b_max;
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
        end
    end

    // Stage C: position of the leading one of the largest magnitude.
    logic [POS_W-1:0] n_c_pos;
    logic [POS_W-1:0] r_c_pos;
    logic             r_c_zero;
    logic [MAG_W-1:0] r_c_mag [0:2];
    logic [2:0]       r_c_neg;

    always_comb begin
        n_c_pos = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_b_max[i]) begin
                n_c_pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_pos  <= n_c_pos;
            r_c_zero <= (r_b_max == '0);
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
        end
    end

    // Stage D: common shift that puts the largest magnitude in [2^29, 2^30).
    logic [FRAC_W-1:0] n_d_a [0:2];
    logic [FRAC_W-1:0] r_d_a [0:2];
    logic [2:0]        r_d_neg;
    logic              r_d_zero;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_c_pos > POS_W'(FRAC_W - 1)) begin
                n_d_a[j] = FRAC_W'(r_c_mag[j] >> (r_c_pos - POS_W'(FRAC_W - 1)));
            end else begin
                n_d_a[j] = FRAC_W'(r_c_mag[j] << (POS_W'(FRAC_W - 1) - r_c_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_a    <= n_d_a;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
        end
    end

    // Stage E: squares.
    logic [SQ_W-1:0]   r_e_sq [0:2];
    logic [FRAC_W-1:0] r_e_a  [0:2];
    logic [2:0]        r_e_neg;
    logic              r_e_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_e_sq[j] <= r_d_a[j] * r_d_a[j];
            end
            r_e_a    <= r_d_a;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;
        end
    end

    // Stage F and the square root steps: one result bit per stage.
    logic [S_W-1:0]    r_s    [0:SQ_STEPS];
    logic [S_W-1:0]    r_r    [0:SQ_STEPS];
    logic [FRAC_W-1:0] r_sa   [0:SQ_STEPS][0:2];
    logic [2:0]        r_sn   [0:SQ_STEPS];
    logic              r_sz   [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]  <= S_W'(r_e_sq[0]) + S_W'(r_e_sq[1]) + S_W'(r_e_sq[2]);
            r_r[0]  <= '0;
            r_sa[0] <= r_e_a;
            r_sn[0] <= r_e_neg;
            r_sz[0] <= r_e_zero;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [S_W:0] trial;

        assign trial = {1'b0, r_r[k]} + {1'b0, BIT};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_s[k]} >= trial) begin
                    r_s[k+1] <= r_s[k] - S_W'(trial);
                    r_r[k+1] <= (r_r[k] >> 1) + BIT;
                end else begin
                    r_s[k+1] <= r_s[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
                r_sa[k+1] <= r_sa[k];
                r_sn[k+1] <= r_sn[k];
                r_sz[k+1] <= r_sz[k];
            end
        end
    end

    // Stage G: rounded numerators, then the restoring division steps.
    logic [LEN_W-1:0] w_len;
    logic [NUM_W-1:0] r_n   [0:DV_STEPS][0:2];
    logic [LEN_W-1:0] r_q   [0:DV_STEPS][0:2];
    logic [LEN_W-1:0] r_len [0:DV_STEPS];
    logic [2:0]       r_dn  [0:DV_STEPS];
    logic             r_dz  [0:DV_STEPS];

    assign w_len = r_r[SQ_STEPS][LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_n[0][j] <= (NUM_W'(r_sa[SQ_STEPS][j]) << FRAC_W) + NUM_W'(w_len >> 1);
                r_q[0][j] <= '0;
            end
            r_len[0] <= w_len;
            r_dn[0]  <= r_sn[SQ_STEPS];
            r_dz[0]  <= r_sz[SQ_STEPS];
        end
    end

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
        localparam int unsigned SH = DV_STEPS - 1 - k;
        logic [NUM_W+1:0] dvs;

        assign dvs = (NUM_W + 2)'(r_len[k]) << SH;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    if ((NUM_W + 2)'(r_n[k][j]) >= dvs) begin
                        r_n[k+1][j] <= r_n[k][j] - NUM_W'(dvs);
                        r_q[k+1][j] <= {r_q[k][j][LEN_W-2:0], 1'b1};
                    end else begin
                        r_n[k+1][j] <= r_n[k][j];
                        r_q[k+1][j] <= {r_q[k][j][LEN_W-2:0], 1'b0};
                    end
                end
                r_len[k+1] <= r_len[k];
                r_dn[k+1]  <= r_dn[k];
                r_dz[k+1]  <= r_dz[k];
            end
        end
    end

    // Stage H: signs back; a zero-length vector gives a zero result.
    t_q230 r_unit [0:2];
    logic  r_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                if (r_dz[DV_STEPS]) begin
                    r_unit[j] <= '0;
                end else if (r_dn[DV_STEPS][j]) begin
                    r_unit[j] <= -$signed({1'b0, r_q[DV_STEPS][j]});
                end else begin
                    r_unit[j] <= $signed({1'b0, r_q[DV_STEPS][j]});
                end
            end
            r_zero <= r_dz[DV_STEPS];
        end
    end

    assign o_unit = r_unit;
    assign o_zero = r_zero;

endmodule

/* sv/look_at_view_matrix.sv */
// Channel  Direction  Handshake                 Beat
// in       input      i_in_valid / o_in_stall   t_in_beat: eye, target, up (Q16.16)
// out      output     o_out_valid / i_out_stall t_out_beat: one matrix row
//
// Each item gives three row beats, one per cycle while i_out_stall is low; the single output port
// for rows thus limits how often the block can take in a new item.
// Two normalizers in series, each a 31-stage square root and a 31-stage divider, set the latency.
// Reset clears only the valid bits and the row counter.
// A stall freezes the whole pipeline in place, but only once its last stage holds a valid item.
module look_at_view_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lav_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lav_pkg::t_out_beat o_out_data
);
    import lav_pkg::*;

    localparam int unsigned RND_W = 34;

    // Magnitude of a value rounded from Q.30 to an integer, half away from zero.
    function automatic logic [RND_W-1:0] round_mag(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = m + (64'(1) << 29);
        return RND_W'(m >> 30);
    endfunction

    logic adv;
    logic take;

    logic signed [31:0] w_eye [0:2];
    logic signed [31:0] w_tgt [0:2];
    logic signed [31:0] w_up  [0:2];

    assign w_eye = '{i_in_data.eye_x, i_in_data.eye_y, i_in_data.eye_z};
    assign w_tgt = '{i_in_data.target_x, i_in_data.target_y, i_in_data.target_z};
    assign w_up  = '{i_in_data.up_x, i_in_data.up_y, i_in_data.up_z};

    // Input stage: back direction (eye minus target) and sign-extended up vector.
    logic               r0_v;
    logic signed [31:0] r0_eye [0:2];
    t_wide              r0_d   [0:2];
    t_wide              r0_up  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (adv) begin
            r0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r0_eye[j] <= w_eye[j];
                r0_d[j]   <= VEC_W'(w_eye[j]) - VEC_W'(w_tgt[j]);
                r0_up[j]  <= VEC_W'(w_up[j]);
            end
        end
    end

    // Back axis and unit up vector, normalized side by side.
    t_q230 w_z [0:2];
    t_q230 w_u [0:2];
    logic  w_zf;
    logic  w_uf;

    lav_norm u_norm_z (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vec  (r0_d),
        .o_unit (w_z),
        .o_zero (w_zf)
    );

    lav_norm u_norm_up (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vec  (r0_up),
        .o_unit (w_u),
        .o_zero (w_uf)
    );

    // Eye and valid bits wait for the first normalizers.
    logic               r_da_v   [0:NORM_LAT-1];
    logic signed [31:0] r_da_eye [0:NORM_LAT-1][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NORM_LAT; i++) begin
                r_da_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_da_v[0] <= r0_v;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_da_v[i] <= r_da_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_da_eye[0] <= r0_eye;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_da_eye[i] <= r_da_eye[i-1];
            end
        end
    end

    // Cross product of up with back axis: products, then differences.
    logic               r1_v;
    logic signed [63:0] r1_p   [0:5];
    t_q230              r1_z   [0:2];
    logic signed [31:0] r1_eye [0:2];
    logic               r1_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= r_da_v[NORM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_p[0] <= w_u[1] * w_z[2];
            r1_p[1] <= w_u[2] * w_z[1];
            r1_p[2] <= w_u[2] * w_z[0];
            r1_p[3] <= w_u[0] * w_z[2];
            r1_p[4] <= w_u[0] * w_z[1];
            r1_p[5] <= w_u[1] * w_z[0];
            r1_z    <= w_z;
            r1_eye  <= r_da_eye[NORM_LAT-1];
            r1_bad  <= w_zf | w_uf;
        end
    end

    logic               r2_v;
    t_wide              r2_c   [0:2];
    t_q230              r2_z   [0:2];
    logic signed [31:0] r2_eye [0:2];
    logic               r2_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r2_c[j] <= VEC_W'(r1_p[2*j] - r1_p[2*j+1]);
            end
            r2_z   <= r1_z;
            r2_eye <= r1_eye;
            r2_bad <= r1_bad;
        end
    end

    // Side axis.
    t_q230 w_x [0:2];
    logic  w_xf;

    lav_norm u_norm_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vec  (r2_c),
        .o_unit (w_x),
        .o_zero (w_xf)
    );

    // Back axis, eye and flags wait for the side-axis normalizer.
    logic               r_db_v   [0:NORM_LAT-1];
    t_q230              r_db_z   [0:NORM_LAT-1][0:2];
    logic signed [31:0] r_db_eye [0:NORM_LAT-1][0:2];
    logic               r_db_bad [0:NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NORM_LAT; i++) begin
                r_db_v[i] <= 1'b0;
            end
        end else if (adv) begin
            r_db_v[0] <= r2_v;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_db_v[i] <= r_db_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_db_z[0]   <= r2_z;
            r_db_eye[0] <= r2_eye;
            r_db_bad[0] <= r2_bad;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_db_z[i]   <= r_db_z[i-1];
                r_db_eye[i] <= r_db_eye[i-1];
                r_db_bad[i] <= r_db_bad[i-1];
            end
        end
    end

    // Up axis: cross product of back axis with side axis, in three steps.
    logic               r3_v;
    logic signed [63:0] r3_p   [0:5];
    t_q230              r3_x   [0:2];
    t_q230              r3_z   [0:2];
    logic signed [31:0] r3_eye [0:2];
    logic               r3_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r_db_v[NORM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_p[0] <= r_db_z[NORM_LAT-1][1] * w_x[2];
            r3_p[1] <= r_db_z[NORM_LAT-1][2] * w_x[1];
            r3_p[2] <= r_db_z[NORM_LAT-1][2] * w_x[0];
            r3_p[3] <= r_db_z[NORM_LAT-1][0] * w_x[2];
            r3_p[4] <= r_db_z[NORM_LAT-1][0] * w_x[1];
            r3_p[5] <= r_db_z[NORM_LAT-1][1] * w_x[0];
            r3_x    <= w_x;
            r3_z    <= r_db_z[NORM_LAT-1];
            r3_eye  <= r_db_eye[NORM_LAT-1];
            r3_bad  <= r_db_bad[NORM_LAT-1] | w_xf;
        end
    end

    logic               r4_v;
    logic signed [63:0] r4_c   [0:2];
    t_q230              r4_x   [0:2];
    t_q230              r4_z   [0:2];
    logic signed [31:0] r4_eye [0:2];
    logic               r4_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r4_c[j] <= r3_p[2*j] - r3_p[2*j+1];
            end
            r4_x   <= r3_x;
            r4_z   <= r3_z;
            r4_eye <= r3_eye;
            r4_bad <= r3_bad;
        end
    end

    logic               r5_v;
    t_q230              r5_y   [0:2];
    t_q230              r5_x   [0:2];
    t_q230              r5_z   [0:2];
    logic signed [31:0] r5_eye [0:2];
    logic               r5_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                if (r4_c[j][63]) begin
                    r5_y[j] <= 32'(-round_mag(r4_c[j]));
                end else begin
                    r5_y[j] <= 32'(round_mag(r4_c[j]));
                end
            end
            r5_x   <= r4_x;
            r5_z   <= r4_z;
            r5_eye <= r4_eye;
            r5_bad <= r4_bad;
        end
    end

    // Rows assembled; a degenerate item gets zero axes.
    logic               r6_v;
    t_q230              r6_ax  [0:2][0:2];
    logic signed [31:0] r6_eye [0:2];
    logic               r6_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r6_ax[ROW_SIDE][j] <= r5_bad ? '0 : r5_x[j];
                r6_ax[ROW_UP][j]   <= r5_bad ? '0 : r5_y[j];
                r6_ax[ROW_BACK][j] <= r5_bad ? '0 : r5_z[j];
            end
            r6_eye <= r5_eye;
            r6_bad <= r5_bad;
        end
    end

    // Translation terms: products, sums, then rounding and negation.
    logic               r7_v;
    logic signed [63:0] r7_p  [0:2][0:2];
    t_q230              r7_ax [0:2][0:2];
    logic               r7_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (adv) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r7_p[r][j] <= r6_ax[r][j] * r6_eye[j];
                end
            end
            r7_ax  <= r6_ax;
            r7_bad <= r6_bad;
        end
    end

    logic               r8_v;
    logic signed [63:0] r8_dot [0:2];
    t_q230              r8_ax  [0:2][0:2];
    logic               r8_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (adv) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r8_dot[r] <= r7_p[r][0] + r7_p[r][1] + r7_p[r][2];
            end
            r8_ax  <= r7_ax;
            r8_bad <= r7_bad;
        end
    end

    logic               r9_v;
    logic signed [39:0] r9_sh [0:2];
    t_q230              r9_ax [0:2][0:2];
    logic               r9_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (adv) begin
            r9_v <= r8_v;
        end
    end

    // The magnitude is widened to the full term width before it is negated.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                if (r8_dot[r][63]) begin
                    r9_sh[r] <= $signed({6'd0, round_mag(r8_dot[r])});
                end else begin
                    r9_sh[r] <= -$signed({6'd0, round_mag(r8_dot[r])});
                end
            end
            r9_ax  <= r8_ax;
            r9_bad <= r8_bad;
        end
    end

    // Output register: holds one item and sends its three rows as beats.
    logic               r_ov;
    logic [1:0]         r_cnt;
    logic signed [39:0] r_osh [0:2];
    t_q230              r_oax [0:2][0:2];
    logic               r_obad;

    assign take = !r_ov || (r_cnt == ROW_BACK && !i_out_stall);
    assign adv  = !r9_v || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_cnt <= ROW_SIDE;
        end else if (take) begin
            r_ov  <= r9_v;
            r_cnt <= ROW_SIDE;
        end else if (!i_out_stall) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_osh  <= r9_sh;
            r_oax  <= r9_ax;
            r_obad <= r9_bad;
        end
    end

    assign o_in_stall              = !adv;
    assign o_out_valid             = r_ov;
    assign o_out_data.row_index    = r_cnt;
    assign o_out_data.axis_x       = r_oax[r_cnt][0];
    assign o_out_data.axis_y       = r_oax[r_cnt][1];
    assign o_out_data.axis_z       = r_oax[r_cnt][2];
    assign o_out_data.shift_term   = r_osh[r_cnt];
    assign o_out_data.degenerate   = r_obad;
    assign o_out_data.last_row     = (r_cnt == ROW_BACK);

endmodule
